>>> design/bilinear_grid_resampler_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bilinear grid resampler
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_GRID_RESAMPLER_UNIT_MACROS_SVH
`define BILINEAR_GRID_RESAMPLER_UNIT_MACROS_SVH

// same-cycle implication
`define BGR_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication
`define BGR_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> design/bgr_pkg.sv
// ----------------------------------------------------------------------------
// bgr_pkg
// Shared types, widths and codes of the bilinear grid resampler.
// ----------------------------------------------------------------------------
package bgr_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int FRAC_BITS   = 16;
  localparam int MAX_DIM     = 256;
  localparam int SRC_CELLS   = 4096;

  localparam int CFG_W   = 9;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  // (2*col+1)*src + dst peaks at 2*MAX_DIM^2
  localparam int NUM_W   = $clog2(2 * MAX_DIM * MAX_DIM + 1);
  localparam int DVD_W   = NUM_W + FRAC_BITS;
  localparam int DVS_W   = DIM_W + 1;
  localparam int QUO_W   = DIM_W + FRAC_BITS;
  localparam int WGT_W   = FRAC_BITS + 1;
  localparam int PW_W    = 2 * FRAC_BITS + 1;
  localparam int PROD_W  = SAMPLE_BITS + PW_W;
  localparam int ACC_W   = PROD_W + 2;
  localparam int ADDR_W  = 2 * DIM_W;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_DST_WIDTH  = 2'd2,
    REG_DST_HEIGHT = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_LOAD_DONE = 2'd0,
    ST_VALUE     = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  typedef struct packed {
    logic               command;
    logic [7:0]         col;
    logic [7:0]         row;
    logic signed [31:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic clr;
    logic wgt_en;
    logic mul_en;
    logic acc_en;
  } mac_ctrl_t;

endpackage

>>> design/bilinear_grid_resampler_unit.sv
// ----------------------------------------------------------------------------
// bilinear_grid_resampler_unit
// Cell-centred bilinear resize of a source grid held in on-chip memory.
// ----------------------------------------------------------------------------
// Load items write one Q15.16 sample at row*src_width+col and answer status 0
// (status 2 when the cell lies off the grid or past the memory). Query items
// map a destination cell centre to the source grid, blend the four clamped
// neighbours and answer the Q15.16 value with status 1, or zero with status 2
// when the cell is outside the destination grid or the source grid does not
// fit the memory. A load, or any item answered out of range, goes from
// acceptance through S_DONE to the output register, where S_DONE waits while
// the output register holds an untaken result. A query runs two passes of
// one shared radix-2 divider (one for x and one for y), the S_IDX step once
// the neighbour indices are registered, then four read/multiply/accumulate
// rounds on the single read port of the grid memory, and S_DONE to the output
// register. The divider and the single read port set the length of a query.
// The input side is busy until the result sits in the output register; the
// input is ready again in that same cycle. The output register lets the next
// item in while the last result waits.
// The grid memory has no reset: reading a cell never loaded gives junk.
// Write configuration only while no item is in flight.
// ----------------------------------------------------------------------------
module bilinear_grid_resampler_unit #(
  parameter int SRC_CELLS = bgr_pkg::SRC_CELLS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  bgr_pkg::in_item_t         in_item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output bgr_pkg::out_item_t        out_item_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [bgr_pkg::CFG_W-1:0] cfg_data_i
);

  `include "bilinear_grid_resampler_unit_macros.svh"

  localparam int RAM_AW = (SRC_CELLS > 1) ? $clog2(SRC_CELLS) : 1;
  localparam int DW     = bgr_pkg::DIM_W;
  localparam int FB     = bgr_pkg::FRAC_BITS;
  localparam int QW     = bgr_pkg::QUO_W;
  localparam int WW     = bgr_pkg::WGT_W;
  localparam int ADW    = bgr_pkg::ADDR_W;
  localparam int NW     = bgr_pkg::NUM_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIVX,
    S_DIVY,
    S_IDX,
    S_RD,
    S_MUL,
    S_ACC,
    S_DONE
  } state_e;

  // effective dimension: zero acts as one, large values clip to MAX_DIM
  function automatic logic [DW-1:0] eff_dim(input logic [bgr_pkg::CFG_W-1:0] raw);
    logic [DW-1:0] r;
    if (raw == '0) begin
      r = DW'(1);
    end else if (raw > bgr_pkg::CFG_W'(bgr_pkg::MAX_DIM)) begin
      r = DW'(bgr_pkg::MAX_DIM);
    end else begin
      r = DW'(raw);
    end
    return r;
  endfunction

  // clip an index to the top of the grid
  function automatic logic [DW-1:0] clip_hi(input logic [DW-1:0] v, input logic [DW-1:0] hi);
    return (v > hi) ? hi : v;
  endfunction

  // ---- configuration registers
  logic [bgr_pkg::CFG_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= bgr_pkg::CFG_W'(1);
      src_h_q <= bgr_pkg::CFG_W'(1);
      dst_w_q <= bgr_pkg::CFG_W'(1);
      dst_h_q <= bgr_pkg::CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bgr_pkg::REG_SRC_WIDTH:  src_w_q <= cfg_data_i;
        bgr_pkg::REG_SRC_HEIGHT: src_h_q <= cfg_data_i;
        bgr_pkg::REG_DST_WIDTH:  dst_w_q <= cfg_data_i;
        bgr_pkg::REG_DST_HEIGHT: dst_h_q <= cfg_data_i;
      endcase
    end
  end

  logic [DW-1:0] sw, sh, dw, dh;
  assign sw = eff_dim(src_w_q);
  assign sh = eff_dim(src_h_q);
  assign dw = eff_dim(dst_w_q);
  assign dh = eff_dim(dst_h_q);

  // ---- sequencer state
  state_e             state_q;
  logic [1:0]         k_q;
  logic [7:0]         row_q;
  logic [QW-1:0]      qx_q;
  logic [DW-1:0]      i0_q, i1_q, j0_q, j1_q;
  logic [WW-1:0]      wx0_q, wx1_q, wy0_q, wy1_q;
  logic [1:0]         res_status_q;
  logic               out_valid_q;
  bgr_pkg::out_item_t out_q;

  logic in_accept, is_load;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign is_load    = (in_item_i.command == bgr_pkg::CMD_LOAD);

  // ---- range checks at acceptance
  logic [ADW-1:0] load_addr, area;
  logic           load_ok, query_ok;

  assign load_addr = ADW'({1'b0, in_item_i.row}) * ADW'(sw) + ADW'(in_item_i.col);
  assign area      = ADW'(sw) * ADW'(sh);
  assign load_ok   = ({1'b0, in_item_i.col} < sw) && ({1'b0, in_item_i.row} < sh)
                     && (load_addr < ADW'(SRC_CELLS));
  assign query_ok  = ({1'b0, in_item_i.col} < dw) && ({1'b0, in_item_i.row} < dh)
                     && (area <= ADW'(SRC_CELLS));

  // ---- shared divider: pos + 1.0 = ((2c+1)*s + d) * 2^FB / (2d), never negative
  logic [7:0]                c_sel;
  logic [DW-1:0]             s_sel, d_sel;
  logic [NW-1:0]             num;
  logic                      div_start;
  logic [QW-1:0]             div_quo;
  bgr_pkg::div_stat_t        div_stat;

  assign c_sel = (state_q == S_IDLE) ? in_item_i.col : row_q;
  assign s_sel = (state_q == S_IDLE) ? sw : sh;
  assign d_sel = (state_q == S_IDLE) ? dw : dh;
  assign num   = NW'({c_sel, 1'b1}) * NW'(s_sel) + NW'(d_sel);

  assign div_start = (in_accept && !is_load && query_ok)
                     || (state_q == S_DIVX && div_stat.done);

  bgr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({num, {FB{1'b0}}}),
    .divisor_i  ({d_sel, 1'b0}),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  // ---- neighbour indices and weights from both quotients
  // quotient high part h = floor index + 1; low part = fraction
  logic [DW-1:0] hx, hy, sw_m1, sh_m1;
  logic [WW-1:0] one_w;

  assign hx    = qx_q[QW-1:FB];
  assign hy    = div_quo[QW-1:FB];
  assign sw_m1 = sw - 1'b1;
  assign sh_m1 = sh - 1'b1;
  assign one_w = WW'(1) << FB;

  // ---- grid memory
  logic [RAM_AW-1:0]                   raddr;
  logic [ADW-1:0]                      raddr_full;
  logic [DW-1:0]                       ri, rj;
  logic signed [bgr_pkg::SAMPLE_BITS-1:0] rdata;

  assign ri         = k_q[0] ? i1_q : i0_q;
  assign rj         = k_q[1] ? j1_q : j0_q;
  assign raddr_full = ADW'(rj) * ADW'(sw) + ADW'(ri);
  assign raddr      = raddr_full[RAM_AW-1:0];

  bgr_ram #(
    .WIDTH (bgr_pkg::SAMPLE_BITS),
    .DEPTH (SRC_CELLS)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (in_accept && is_load && load_ok),
    .waddr_i (load_addr[RAM_AW-1:0]),
    .wdata_i (in_item_i.sample),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // ---- blend unit
  bgr_pkg::mac_ctrl_t                    mac_ctrl;
  logic signed [bgr_pkg::SAMPLE_BITS-1:0] mac_value;

  assign mac_ctrl.clr    = (state_q == S_IDX);
  assign mac_ctrl.wgt_en = (state_q == S_RD);
  assign mac_ctrl.mul_en = (state_q == S_MUL);
  assign mac_ctrl.acc_en = (state_q == S_ACC);

  bgr_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .wx_i    (k_q[0] ? wx1_q : wx0_q),
    .wy_i    (k_q[1] ? wy1_q : wy0_q),
    .smp_i   (rdata),
    .value_o (mac_value)
  );

  // ---- sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      k_q          <= '0;
      res_status_q <= bgr_pkg::ST_RANGE;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      // result register: refilled from S_DONE, emptied when taken
      if (state_q == S_DONE && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            if (is_load) begin
              res_status_q <= load_ok ? bgr_pkg::ST_LOAD_DONE : bgr_pkg::ST_RANGE;
              state_q      <= S_DONE;
            end else if (query_ok) begin
              state_q <= S_DIVX;
            end else begin
              res_status_q <= bgr_pkg::ST_RANGE;
              state_q      <= S_DONE;
            end
          end
        end
        S_DIVX: begin
          if (div_stat.done) begin
            state_q <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_stat.done) begin
            state_q <= S_IDX;
          end
        end
        S_IDX: begin
          k_q     <= '0;
          state_q <= S_RD;
        end
        S_RD: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (k_q == 2'd3) begin
            res_status_q <= bgr_pkg::ST_VALUE;
            state_q      <= S_DONE;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.status <= res_status_q;
            out_q.value  <= (res_status_q == bgr_pkg::ST_VALUE) ? mac_value : '0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // payload-only registers: operands kept for the y pass, indices, weights
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      row_q <= in_item_i.row;
    end
    if (state_q == S_DIVX && div_stat.done) begin
      qx_q <= div_quo;
    end
    if (state_q == S_DIVY && div_stat.done) begin
      i1_q  <= clip_hi(hx, sw_m1);
      i0_q  <= (hx == '0) ? '0 : clip_hi(hx - 1'b1, sw_m1);
      j1_q  <= clip_hi(hy, sh_m1);
      j0_q  <= (hy == '0) ? '0 : clip_hi(hy - 1'b1, sh_m1);
      wx1_q <= {1'b0, qx_q[FB-1:0]};
      wx0_q <= one_w - {1'b0, qx_q[FB-1:0]};
      wy1_q <= {1'b0, div_quo[FB-1:0]};
      wy0_q <= one_w - {1'b0, div_quo[FB-1:0]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // ---- assertions
  `BGR_ASSERT_NOW(a_div_no_restart, div_start, !div_stat.busy, "divider restarted while busy")
  `BGR_ASSERT_NOW(a_busy_blocks_in, div_stat.busy, !in_ready_o, "item accepted during division")
  `BGR_ASSERT_NOW(a_quo_bound, div_stat.done, hy <= DW'(bgr_pkg::MAX_DIM), "quotient overflow")
  `BGR_ASSERT_NEXT(a_y_pass_runs, state_q == S_DIVX && div_stat.done, div_stat.busy,
                   "y division did not start")

endmodule

>>> design/bgr_ram.sv
// ----------------------------------------------------------------------------
// bgr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bgr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/bgr_div.sv
// ----------------------------------------------------------------------------
// bgr_div
// Restoring divider, one quotient bit per cycle. Quotient must fit QUO_W bits.
// ----------------------------------------------------------------------------
module bgr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bgr_pkg::DVD_W-1:0] dividend_i,
  input  logic [bgr_pkg::DVS_W-1:0] divisor_i,
  output logic [bgr_pkg::QUO_W-1:0] quotient_o,
  output bgr_pkg::div_stat_t        stat_o
);

  localparam int QW    = bgr_pkg::QUO_W;
  localparam int RW    = bgr_pkg::DVS_W;
  localparam int TOP_W = bgr_pkg::DVD_W - QW;
  localparam int CNT_W = $clog2(QW);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RW-1:0]    rem_q, dvs_q;
  logic [QW-1:0]    quo_q;
  logic [RW:0]      trial;
  logic             fits;

  // partial remainder with next dividend bit, then compare/subtract
  assign trial = {rem_q, quo_q[QW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= RW'(dividend_i[bgr_pkg::DVD_W-1 -: TOP_W]);
      quo_q <= dividend_i[QW-1:0];
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? RW'(trial - {1'b0, dvs_q}) : trial[RW-1:0];
      quo_q <= {quo_q[QW-2:0], fits};
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

>>> design/bgr_mac.sv
// ----------------------------------------------------------------------------
// bgr_mac
// Weight multiply, sample multiply and wide accumulate for the blend,
// then floor shift and saturation to the sample range.
// ----------------------------------------------------------------------------
module bgr_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  bgr_pkg::mac_ctrl_t                    ctrl_i,
  input  logic [bgr_pkg::WGT_W-1:0]             wx_i,
  input  logic [bgr_pkg::WGT_W-1:0]             wy_i,
  input  logic signed [bgr_pkg::SAMPLE_BITS-1:0] smp_i,
  output logic signed [bgr_pkg::SAMPLE_BITS-1:0] value_o
);

  localparam int SB   = bgr_pkg::SAMPLE_BITS;
  localparam int FB2  = 2 * bgr_pkg::FRAC_BITS;
  localparam int PW   = bgr_pkg::PW_W;
  localparam int PRW  = bgr_pkg::PROD_W;
  localparam int AW   = bgr_pkg::ACC_W;
  localparam int SH_W = AW - FB2;

  logic [2*bgr_pkg::WGT_W-1:0] wprod;
  logic [PW-1:0]               w_q;
  logic signed [PRW-1:0]       mul_p, prod_d, prod_q;
  logic signed [AW-1:0]        acc_q;
  logic [SH_W-1:0]             sh;
  logic [SH_W-SB:0]            top_bits;

  assign wprod = wx_i * wy_i;
  assign mul_p = smp_i * $signed({1'b0, w_q[PW-2:0]});
  // full weight of one only when both fractions are zero: a plain shift
  assign prod_d = w_q[PW-1] ? {{(PRW - SB - FB2){smp_i[SB-1]}}, smp_i, {FB2{1'b0}}} : mul_p;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wgt_en) begin
      w_q <= wprod[PW-1:0];
    end
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= acc_q + AW'(prod_q);
    end
  end

  assign sh       = acc_q[AW-1:FB2];
  assign top_bits = sh[SH_W-1:SB-1];

  always_comb begin
    if (top_bits == '0 || top_bits == '1) begin
      value_o = sh[SB-1:0];
    end else if (sh[SH_W-1]) begin
      value_o = {1'b1, {(SB - 1){1'b0}}};
    end else begin
      value_o = {1'b0, {(SB - 1){1'b1}}};
    end
  end

endmodule

>>> tb/tb_bilinear_grid_resampler_unit.sv
// ----------------------------------------------------------------------------
// tb_bilinear_grid_resampler_unit
// Self-checking bench for the bilinear grid resampler. Loads and queries are
// sent over the valid/ready input while an internal predictor keeps its own
// copy of the grid and the dimension registers. Each result is compared
// field by field, in order, against the predicted answer.
// ----------------------------------------------------------------------------
module tb_bilinear_grid_resampler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bgr_pkg::*;

  localparam int     HOLD_CYCLES = 300;   // long output hold-off, fills the block
  localparam longint VAL_MAX     = 64'sd2147483647;
  localparam longint VAL_MIN     = -64'sd2147483648;

  // --------------------------------------------------------------------------
  // Predictor and result store
  // --------------------------------------------------------------------------
  class resize_scoreboard;
    logic [CFG_W-1:0]   dim_reg [4] = '{default: 9'd1};
    logic signed [31:0] grid_mem [SRC_CELLS];
    bit                 loaded [SRC_CELLS];
    out_item_t          pending_answers [$];
    int                 errors;
    int                 n_stored;
    int                 n_values;
    int                 n_range;

    function void set_reg(reg_idx_e idx, logic [CFG_W-1:0] data);
      dim_reg[idx] = data;
    endfunction

    // zero reads as one, anything past the maximum reads as the maximum
    function int eff_dim(logic [CFG_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > MAX_DIM) return MAX_DIM;
      return int'(raw);
    endfunction

    function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
    endfunction

    function longint clip(longint v, longint hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
    endfunction

    // cell centre to source position: floor index and Q0.16 fraction
    function void map_axis(longint c, longint s, longint d,
                           output longint idx, output longint frac);
      longint pos;
      pos  = floor_div(((2 * c + 1) * s - d) * (longint'(1) << FRAC_BITS), 2 * d);
      idx  = pos >>> FRAC_BITS;
      frac = pos - (idx << FRAC_BITS);
    endfunction

    // Grid addresses of the four neighbours of a query and its fractions.
    // Returns 0 when the query answers out of range and reads nothing.
    function bit cell_taps(logic [7:0] col, logic [7:0] row, output int addr [4],
                           output longint tx, output longint ty);
      longint sw, sh, dw, dh, c, r, i0, i1, j0, j1;
      sw   = eff_dim(dim_reg[REG_SRC_WIDTH]);
      sh   = eff_dim(dim_reg[REG_SRC_HEIGHT]);
      dw   = eff_dim(dim_reg[REG_DST_WIDTH]);
      dh   = eff_dim(dim_reg[REG_DST_HEIGHT]);
      c    = col;
      r    = row;
      addr = '{default: 0};
      tx   = 0;
      ty   = 0;
      if (c >= dw || r >= dh || sw * sh > SRC_CELLS) return 1'b0;
      map_axis(c, sw, dw, i0, tx);
      map_axis(r, sh, dh, j0, ty);
      i1 = clip(i0 + 1, sw - 1);
      j1 = clip(j0 + 1, sh - 1);
      i0 = clip(i0, sw - 1);
      j0 = clip(j0, sh - 1);
      addr[0] = int'(j0 * sw + i0);
      addr[1] = int'(j0 * sw + i1);
      addr[2] = int'(j1 * sw + i0);
      addr[3] = int'(j1 * sw + i1);
      return 1'b1;
    endfunction

    // exact weighted sum, floor shift by 32, saturate to the sample range
    function logic signed [31:0] blend_taps(int addr [4], longint tx, longint ty);
      logic signed [95:0] acc, term, shifted;
      longint             w [4];
      longint             one, res;
      one  = longint'(1) << FRAC_BITS;
      w[0] = (one - tx) * (one - ty);
      w[1] = tx * (one - ty);
      w[2] = (one - tx) * ty;
      w[3] = tx * ty;
      acc  = '0;
      for (int k = 0; k < 4; k++) begin
        term = grid_mem[addr[k]];
        acc  = acc + term * w[k];
      end
      shifted = acc >>> (2 * FRAC_BITS);
      res     = shifted[63:0];
      if (res > VAL_MAX) res = VAL_MAX;
      if (res < VAL_MIN) res = VAL_MIN;
      return res[31:0];
    endfunction

    function void note_item(in_item_t it);
      out_item_t ans;
      int        addr [4];
      longint    tx, ty, sw, sh, c, r, a;
      ans.value  = '0;
      ans.status = ST_RANGE;
      if (it.command == CMD_LOAD) begin
        sw = eff_dim(dim_reg[REG_SRC_WIDTH]);
        sh = eff_dim(dim_reg[REG_SRC_HEIGHT]);
        c  = it.col;
        r  = it.row;
        a  = r * sw + c;
        if (c < sw && r < sh && a < SRC_CELLS) begin
          grid_mem[a] = it.sample;
          loaded[a]   = 1'b1;
          ans.status  = ST_LOAD_DONE;
          n_stored++;
        end else begin
          n_range++;
        end
      end else if (cell_taps(it.col, it.row, addr, tx, ty)) begin
        ans.value  = blend_taps(addr, tx, ty);
        ans.status = ST_VALUE;
        n_values++;
      end else begin
        n_range++;
      end
      pending_answers = {pending_answers, ans};
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result, value %h status %0d", $time, got.value, got.status);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      if (got.value !== want.value) begin
        $display("%0t: value mismatch, expected %h, actual %h", $time, want.value, got.value);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test
  // --------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_item;
  logic             cfg_we;
  reg_idx_e         cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bilinear_grid_resampler_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #4ns clk = ~clk;

  resize_scoreboard sb = new;

  bit calm     = 1'b0;   // no idling on either side while set
  bit hold_req = 1'b0;   // asks the output side for one long hold-off
  int items_sent;
  int n_settings;

  // Full-scale and sign-boundary samples for the first grid
  logic signed [31:0] extreme_samples [12] = '{
    32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF,
    32'sh0001_0000, 32'shFFFF_0000, 32'sh7FFF_0000, 32'sh8001_0000,
    32'sh0000_0001, 32'sh1234_5678, 32'shEDCB_A988, 32'sh0000_8000
  };

  // Mostly back-to-back, sometimes short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(20, 70);
  endfunction

  function automatic logic signed [31:0] draw_sample();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // register value: usually a small grid, sometimes anything the field holds
  function automatic int rand_dim();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 511);
    return $urandom_range(1, 12);
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Valid stays up across back-to-back items; it only drops for a gap or
  // when the sender stops (drain).
  task automatic send_item(in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    items_sent++;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic put(logic cmd, int col, int row, logic signed [31:0] smp);
    in_item_t it;
    it.command = cmd;
    it.col     = 8'(col);
    it.row     = 8'(row);
    it.sample  = smp;
    send_item(it);
  endtask

  // Query one destination cell, first loading any neighbour cell the grid
  // memory has never seen (its content would be undefined).
  task automatic query_cell(int col, int row);
    int     addr [4];
    longint tx, ty;
    int     sw;
    sw = sb.eff_dim(sb.dim_reg[REG_SRC_WIDTH]);
    if (sb.cell_taps(8'(col), 8'(row), addr, tx, ty)) begin
      for (int k = 0; k < 4; k++) begin
        if (!sb.loaded[addr[k]]) put(CMD_LOAD, addr[k] % sw, addr[k] / sw, draw_sample());
      end
    end
    put(CMD_QUERY, col, row, $urandom);
  endtask

  // stop offering and wait until every predicted answer has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_e idx, int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(data);
    @(posedge clk);
    sb.set_reg(idx, CFG_W'(data));
  endtask

  // Registers only change while the block is idle
  task automatic set_dims(int sw, int sh, int dw, int dh);
    drain();
    repeat (4) @(posedge clk);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic random_op();
    int sw, sh, dw, dh, r;
    sw = sb.eff_dim(sb.dim_reg[REG_SRC_WIDTH]);
    sh = sb.eff_dim(sb.dim_reg[REG_SRC_HEIGHT]);
    dw = sb.eff_dim(sb.dim_reg[REG_DST_WIDTH]);
    dh = sb.eff_dim(sb.dim_reg[REG_DST_HEIGHT]);
    r  = $urandom_range(0, 99);
    if (r < 55)
      query_cell($urandom_range(0, dw - 1), $urandom_range(0, dh - 1));
    else if (r < 80)
      put(CMD_LOAD, $urandom_range(0, sw - 1), $urandom_range(0, sh - 1), draw_sample());
    else if (r < 90)
      query_cell($urandom_range(0, 255), $urandom_range(0, 255));
    else
      put(CMD_LOAD, $urandom_range(0, 255), $urandom_range(0, 255), draw_sample());
  endtask

  // --------------------------------------------------------------------------
  // Output side: checks each accepted result, then picks ready for the next
  // cycle. Random stalls, plus one long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    int hold_left;
    bit hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_item);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin
    // Fixed register settings first: zero, exact memory fill, oversize grids,
    // above-range values, tall and wide shapes. Then random ones.
    int plan [9][4];
    plan = '{
      '{0, 0, 0, 0},
      '{5, 4, 9, 3},
      '{256, 16, 256, 256},
      '{256, 256, 3, 3},
      '{511, 1, 300, 2},
      '{1, 256, 1, 256},
      '{64, 64, 5, 200},
      '{3, 2, 2, 7},
      '{17, 256, 8, 8}
    };
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SRC_WIDTH;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset dimensions: one-cell grid, the query must return the sample itself
    put(CMD_LOAD, 0, 0, 32'sh0001_8000);
    query_cell(0, 0);
    query_cell(1, 0);
    put(CMD_LOAD, 1, 0, 32'sh7FFF_FFFF);

    // 4x3 grid upsampled to 7x5: corner cells sit off the grid and clamp
    set_dims(4, 3, 7, 5);
    foreach (extreme_samples[k]) put(CMD_LOAD, k % 4, k / 4, extreme_samples[k]);
    query_cell(0, 0);
    query_cell(6, 4);
    query_cell(3, 2);
    query_cell(7, 0);
    query_cell(0, 5);
    query_cell(255, 255);
    put(CMD_LOAD, 4, 0, 32'sh0000_1111);
    put(CMD_LOAD, 0, 3, 32'sh0000_2222);
    put(CMD_LOAD, 255, 255, 32'sh0000_3333);

    for (int p = 0; p < 9 || items_sent < 400; p++) begin
      if (p < 9) set_dims(plan[p][0], plan[p][1], plan[p][2], plan[p][3]);
      else set_dims(rand_dim(), rand_dim(), rand_dim(), rand_dim());
      calm <= (p % 4 == 3);
      // block fills behind a stalled output while items keep coming
      if (p == 1) hold_req <= 1'b1;
      for (int k = 0; k < 30; k++) begin
        if (p == 2 && k == 15) drain();
        random_op();
      end
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d items under %0d register settings: %0d samples stored,",
             items_sent, n_settings, sb.n_stored);
    $display("  %0d blended values, %0d range answers, one %0d-cycle output hold-off.",
             sb.n_values, sb.n_range, HOLD_CYCLES);
    if (sb.errors == 0 && sb.pending_answers.size() == 0)
      $display("tb_bilinear_grid_resampler_unit OK");
    else
      $display("tb_bilinear_grid_resampler_unit NOT OK");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #10ms;
    $display("tb_bilinear_grid_resampler_unit NOT OK");
    $finish;
  end

endmodule
